// ----- hdl/ptb_pkg.sv -----
// ----------------------------------------------------------------------------
// Palindromic tree builder package
// Shared types, codes and widths for the builder's controller and datapath.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;

  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 7;
  localparam int COUNT_W  = 11;
  localparam int BEST_W   = 21;
  localparam int LETTER_W = 5;
  localparam int OCC_W    = 11;

  localparam logic [CHAR_W-1:0] LETTER_BASE = 7'd97;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FINISH = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_AFTER_FINISH = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [CHAR_W-1:0]   char_code;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [COUNT_W-1:0]  suffix_palindromes;
    logic [COUNT_W-1:0]  longest_suffix_len;
    logic                is_new;
    logic [COUNT_W-1:0]  distinct_count;
    logic [BEST_W-1:0]   best_product;
  } out_item_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_SWEEP,
    DP_APP_START,
    DP_W_READ,
    DP_W_POS,
    DP_W_CMP,
    DP_CH_CUR,
    DP_CH_UP,
    DP_NODE_RD,
    DP_EXIST_WR,
    DP_WALK2,
    DP_SET_LINK,
    DP_CREATE,
    DP_FOLD_INIT,
    DP_FOLD_RD,
    DP_FOLD_P,
    DP_FOLD_WR,
    DP_MAX_INIT,
    DP_MAX_RD,
    DP_MAX_MUL,
    DP_MAX_CMP,
    DP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    opcode_t opcode;
    logic    finished;
    logic    full;
    logic    match;
    logic    child_nz;
    logic    cur_root;
    logic    idx_ge2;
    logic    idx_lt_nt;
    logic    sweep_last;
  } dp_stat_t;

endpackage

// ----- hdl/palindromic_tree_builder.sv -----
// ----------------------------------------------------------------------------
// Palindromic tree builder
// Takes one command per transfer on the input channel and returns exactly one
// result transfer per command on the output channel.
//
// Each command is taken in the idle state and worked on alone. An append
// walks suffix links from the last node and then looks up or creates the
// child node; the walks are amortized constant per letter. A first finish
// folds the counts along the suffix links and then searches the nodes for
// the best product; a repeated finish runs the search only. A clear, and
// reset itself, sweep the child table one entry per cycle, with in_ready
// low throughout. Reset produces no result; a clear reports after its sweep.
// A finished result sits in an output register; while the receiver stalls
// the block completes the next command and then waits for the register.
// ----------------------------------------------------------------------------
module palindromic_tree_builder import ptb_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_op_t   op;
  dp_stat_t stat;

  ptb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  ptb_dp #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted while a command was still in progress.");

  a_new_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_new |-> out_data.status == ST_OK &&
    out_data.longest_suffix_len != '0)
    else $error("New palindrome reported on an ignored or empty append.");

  a_ignored_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
    out_data.longest_suffix_len == '0 && out_data.suffix_palindromes == '0)
    else $error("Ignored append reported palindrome data.");

endmodule

// ----- hdl/ptb_dp.sv -----
// ----------------------------------------------------------------------------
// Palindromic tree builder datapath
// Node stores, letter store, child table and the registers that one command
// of the controller updates in each cycle.
// ----------------------------------------------------------------------------
module ptb_dp import ptb_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_op_t    op,
  input  in_item_t  in_data,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  localparam int NODE_DEPTH = MAX_LEN + 2;
  localparam int LW         = $clog2(MAX_LEN + 1);
  localparam int NW         = $clog2(NODE_DEPTH);
  localparam int CW         = $clog2(NODE_DEPTH + 1);
  localparam int CD         = NODE_DEPTH * ALPHABET;
  localparam int CAW        = $clog2(CD);
  localparam int PW         = OCC_W + LW;
  localparam int RECIP      = (65536 + ALPHABET - 1) / ALPHABET;

  logic [LETTER_W-1:0] let_mem   [MAX_LEN+1];
  logic [LW-1:0]       len_mem   [NODE_DEPTH];
  logic [NW-1:0]       link_mem  [NODE_DEPTH];
  logic [OCC_W-1:0]    occ_mem   [NODE_DEPTH];
  logic [COUNT_W-1:0]  spt_mem   [NODE_DEPTH];
  logic [NW-1:0]       child_mem [CD];

  opcode_t             opcode_r;
  logic [CHAR_W-1:0]   raw_r;
  logic [CHAR_W-1:0]   q_r;
  logic [LETTER_W-1:0] c_r;
  logic [LW-1:0]       tl_r;
  logic [CW-1:0]       nt_r;
  logic [NW-1:0]       last_r;
  logic                fin_r;
  logic [NW-1:0]       node_r;
  logic [LW:0]         len_q_r;
  logic [NW-1:0]       link_q_r;
  logic                pos_ok_r;
  logic [NW-1:0]       cur_r;
  logic [LW:0]         cur_len_r;
  logic [NW-1:0]       cur_link_r;
  logic [NW-1:0]       v_r;
  logic [NW-1:0]       link_new_r;
  logic [CW-1:0]       idx_r;
  logic [OCC_W-1:0]    occ_i_r;
  logic [NW-1:0]       p_r;
  logic [PW-1:0]       prod_r;
  logic [PW-1:0]       best_r;
  status_t             status_r;
  logic [COUNT_W-1:0]  spt_o_r;
  logic [COUNT_W-1:0]  len_o_r;
  logic                new_o_r;
  logic [CAW-1:0]      sw_r;
  out_item_t           out_r;

  logic [LW-1:0]       len_rd;
  logic [NW-1:0]       link_rd;
  logic [OCC_W-1:0]    occ_rd;
  logic [COUNT_W-1:0]  spt_rd;
  logic [NW-1:0]       rq_r;
  logic [LETTER_W-1:0] let_rd;
  logic [NW-1:0]       child_rd;

  logic                node_rd_en;
  logic [NW-1:0]       rd_node;
  logic                let_re;
  logic [LW-1:0]       let_ra;
  logic                let_we;
  logic                ch_re;
  logic [CAW-1:0]      ch_ra;
  logic                ch_we;
  logic [CAW-1:0]      ch_wa;
  logic [NW-1:0]       ch_wd;
  logic                occ_we;
  logic [NW-1:0]       occ_wa;
  logic [OCC_W-1:0]    occ_wd;
  logic                new_we;

  logic [CHAR_W-1:0]   raw_in;
  logic [23:0]         q_prod;
  logic [CHAR_W-1:0]   qa;
  logic [LETTER_W-1:0] c_calc;
  logic [LW:0]         len_val;
  logic [NW-1:0]       link_val;
  logic [COUNT_W-1:0]  spt_val;
  logic [LW+1:0]       pos;
  logic                pos_ok;
  logic                node_oob;
  logic                match;
  logic [LW-1:0]       new_len;
  logic                p_ok;

  function automatic logic [CAW-1:0] child_addr(input logic [NW-1:0] node,
                                                input logic [LETTER_W-1:0] c);
    child_addr = CAW'(CAW'(node) * CAW'(ALPHABET)) + CAW'(c);
  endfunction

  assign raw_in   = in_data.char_code - LETTER_BASE;
  assign q_prod   = 24'(raw_in) * 24'(RECIP);
  assign qa       = CHAR_W'(14'(q_r) * 14'(ALPHABET));
  assign c_calc   = LETTER_W'(raw_r - qa);

  assign len_val  = (rq_r == NW'(0)) ? '0 :
                    (rq_r == NW'(1)) ? '1 : {1'b0, len_rd};
  assign link_val = (rq_r == NW'(0)) ? NW'(1) :
                    (rq_r == NW'(1)) ? '0 : link_rd;
  assign spt_val  = (rq_r < NW'(2)) ? '0 : spt_rd;

  assign pos      = {2'b00, tl_r} - {len_val[LW], len_val} - (LW+2)'(1);
  assign pos_ok   = !pos[LW+1] && (pos != '0) && (pos[LW:0] <= {1'b0, tl_r});
  assign node_oob = CW'(node_r) >= nt_r;
  assign match    = (node_r == NW'(1)) || node_oob || (pos_ok_r && let_rd == c_r);
  assign new_len  = LW'(cur_len_r + (LW+1)'(2));
  assign p_ok     = (p_r >= NW'(2)) && (CW'(p_r) < nt_r);

  always_comb begin
    node_rd_en = 1'b0;
    rd_node    = node_r;
    let_re     = 1'b0;
    let_ra     = pos[LW-1:0];
    let_we     = 1'b0;
    ch_re      = 1'b0;
    ch_ra      = child_addr(node_r, c_r);
    ch_we      = 1'b0;
    ch_wa      = sw_r;
    ch_wd      = '0;
    occ_we     = 1'b0;
    occ_wa     = v_r;
    occ_wd     = occ_rd + OCC_W'(1);
    new_we     = 1'b0;
    unique case (op)
      DP_SWEEP: begin
        ch_we = 1'b1;
      end
      DP_APP_START: begin
        let_we = 1'b1;
      end
      DP_W_READ: begin
        node_rd_en = 1'b1;
      end
      DP_W_POS: begin
        let_re = 1'b1;
      end
      DP_CH_CUR, DP_CH_UP: begin
        ch_re = 1'b1;
      end
      DP_NODE_RD, DP_SET_LINK: begin
        node_rd_en = 1'b1;
        rd_node    = child_rd;
      end
      DP_EXIST_WR: begin
        occ_we = 1'b1;
      end
      DP_CREATE: begin
        new_we = 1'b1;
        ch_we  = 1'b1;
        ch_wa  = child_addr(cur_r, c_r);
        ch_wd  = nt_r[NW-1:0];
        occ_we = 1'b1;
        occ_wa = nt_r[NW-1:0];
        occ_wd = OCC_W'(1);
      end
      DP_FOLD_RD, DP_MAX_RD: begin
        node_rd_en = 1'b1;
        rd_node    = idx_r[NW-1:0];
      end
      DP_FOLD_P: begin
        node_rd_en = 1'b1;
        rd_node    = link_rd;
      end
      DP_FOLD_WR: begin
        occ_we = p_ok;
        occ_wa = p_r;
        occ_wd = occ_rd + occ_i_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_rd_en) begin
      len_rd  <= len_mem[rd_node];
      link_rd <= link_mem[rd_node];
      occ_rd  <= occ_mem[rd_node];
      spt_rd  <= spt_mem[rd_node];
      rq_r    <= rd_node;
    end
    if (let_re) begin
      let_rd <= let_mem[let_ra];
    end
    if (let_we) begin
      let_mem[tl_r + LW'(1)] <= c_calc;
    end
    if (ch_re) begin
      child_rd <= child_mem[ch_ra];
    end
    if (ch_we) begin
      child_mem[ch_wa] <= ch_wd;
    end
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    if (new_we) begin
      len_mem[nt_r[NW-1:0]]  <= new_len;
      link_mem[nt_r[NW-1:0]] <= link_new_r;
      spt_mem[nt_r[NW-1:0]]  <= spt_val + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r   <= '0;
      nt_r   <= CW'(2);
      last_r <= '0;
      fin_r  <= 1'b0;
      sw_r   <= '0;
    end else begin
      unique case (op)
        DP_LOAD: begin
          opcode_r <= in_data.opcode;
          raw_r    <= raw_in;
          q_r      <= q_prod[16 +: CHAR_W];
          spt_o_r  <= '0;
          len_o_r  <= '0;
          new_o_r  <= 1'b0;
          best_r   <= '0;
          if (in_data.opcode == OP_APPEND && fin_r) begin
            status_r <= ST_AFTER_FINISH;
          end else if (in_data.opcode == OP_APPEND && tl_r == LW'(MAX_LEN)) begin
            status_r <= ST_FULL;
          end else begin
            status_r <= ST_OK;
          end
        end
        DP_CLEAR: begin
          tl_r   <= '0;
          nt_r   <= CW'(2);
          last_r <= '0;
          fin_r  <= 1'b0;
          sw_r   <= '0;
        end
        DP_SWEEP: begin
          sw_r <= sw_r + CAW'(1);
        end
        DP_APP_START: begin
          tl_r   <= tl_r + LW'(1);
          c_r    <= c_calc;
          node_r <= last_r;
        end
        DP_W_POS: begin
          len_q_r  <= len_val;
          link_q_r <= link_val;
          pos_ok_r <= pos_ok;
        end
        DP_W_CMP: begin
          if (!match) begin
            node_r <= link_q_r;
          end else if (node_oob) begin
            node_r  <= NW'(1);
            len_q_r <= '1;
          end
        end
        DP_CH_CUR: begin
          cur_r      <= node_r;
          cur_len_r  <= len_q_r;
          cur_link_r <= link_q_r;
        end
        DP_NODE_RD: begin
          v_r <= child_rd;
        end
        DP_EXIST_WR: begin
          last_r  <= v_r;
          spt_o_r <= spt_val;
          len_o_r <= COUNT_W'(len_rd);
        end
        DP_WALK2: begin
          node_r <= cur_link_r;
        end
        DP_SET_LINK: begin
          link_new_r <= child_rd;
        end
        DP_CREATE: begin
          nt_r    <= nt_r + CW'(1);
          last_r  <= nt_r[NW-1:0];
          spt_o_r <= spt_val + COUNT_W'(1);
          len_o_r <= COUNT_W'(new_len);
          new_o_r <= 1'b1;
        end
        DP_FOLD_INIT: begin
          idx_r <= nt_r - CW'(1);
        end
        DP_FOLD_P: begin
          p_r     <= link_rd;
          occ_i_r <= occ_rd;
        end
        DP_FOLD_WR: begin
          idx_r <= idx_r - CW'(1);
        end
        DP_MAX_INIT: begin
          fin_r  <= 1'b1;
          idx_r  <= CW'(2);
          best_r <= '0;
        end
        DP_MAX_MUL: begin
          prod_r <= PW'(occ_rd) * PW'(len_rd);
        end
        DP_MAX_CMP: begin
          if (prod_r > best_r) begin
            best_r <= prod_r;
          end
          idx_r <= idx_r + CW'(1);
        end
        DP_PUBLISH: begin
          out_r.status             <= status_r;
          out_r.suffix_palindromes <= spt_o_r;
          out_r.longest_suffix_len <= len_o_r;
          out_r.is_new             <= new_o_r;
          out_r.distinct_count     <= COUNT_W'(nt_r - CW'(2));
          out_r.best_product       <= BEST_W'(best_r);
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.opcode     = opcode_r;
  assign stat.finished   = fin_r;
  assign stat.full       = tl_r == LW'(MAX_LEN);
  assign stat.match      = match;
  assign stat.child_nz   = child_rd != '0;
  assign stat.cur_root   = cur_r == NW'(1);
  assign stat.idx_ge2    = idx_r >= CW'(2);
  assign stat.idx_lt_nt  = idx_r < nt_r;
  assign stat.sweep_last = sw_r == CAW'(CD - 1);

  assign out_data = out_r;

endmodule

// ----- hdl/ptb_ctrl.sv -----
// ----------------------------------------------------------------------------
// Palindromic tree builder controller
// Sequences the datapath through the sweep, suffix-link walks, node creation,
// count folding and the best-product search, and owns the handshakes.
// ----------------------------------------------------------------------------
module ptb_ctrl import ptb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  typedef enum logic [4:0] {
    S_SWEEP,
    S_IDLE,
    S_DISPATCH,
    S_WREAD,
    S_WPOS,
    S_WCMP,
    S_CHREAD,
    S_CHDEC,
    S_EXIST,
    S_CREATE,
    S_FOLD_CHK,
    S_FOLD_P,
    S_FOLD_WR,
    S_MAX_CHK,
    S_MAX_MUL,
    S_MAX_CMP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   phase2_r, phase2_nxt;
  logic   reply_r, reply_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    phase2_nxt = phase2_r;
    reply_nxt  = reply_r;
    op         = DP_NOP;
    unique case (state_r)
      S_SWEEP: begin
        op = DP_SWEEP;
        if (stat.sweep_last) begin
          state_nxt = reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = DP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.opcode)
          OP_CLEAR: begin
            op        = DP_CLEAR;
            reply_nxt = 1'b1;
            state_nxt = S_SWEEP;
          end
          OP_APPEND: begin
            if (stat.finished || stat.full) begin
              state_nxt = S_DONE;
            end else begin
              op         = DP_APP_START;
              phase2_nxt = 1'b0;
              state_nxt  = S_WREAD;
            end
          end
          OP_FINISH: begin
            if (stat.finished) begin
              op        = DP_MAX_INIT;
              state_nxt = S_MAX_CHK;
            end else begin
              op        = DP_FOLD_INIT;
              state_nxt = S_FOLD_CHK;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_WREAD: begin
        op        = DP_W_READ;
        state_nxt = S_WPOS;
      end
      S_WPOS: begin
        op        = DP_W_POS;
        state_nxt = S_WCMP;
      end
      S_WCMP: begin
        op        = DP_W_CMP;
        state_nxt = stat.match ? S_CHREAD : S_WREAD;
      end
      S_CHREAD: begin
        op        = phase2_r ? DP_CH_UP : DP_CH_CUR;
        state_nxt = S_CHDEC;
      end
      S_CHDEC: begin
        priority if (phase2_r) begin
          op        = DP_SET_LINK;
          state_nxt = S_CREATE;
        end else if (stat.child_nz) begin
          op        = DP_NODE_RD;
          state_nxt = S_EXIST;
        end else if (stat.cur_root) begin
          op        = DP_SET_LINK;
          state_nxt = S_CREATE;
        end else begin
          op         = DP_WALK2;
          phase2_nxt = 1'b1;
          state_nxt  = S_WREAD;
        end
      end
      S_EXIST: begin
        op        = DP_EXIST_WR;
        state_nxt = S_DONE;
      end
      S_CREATE: begin
        op        = DP_CREATE;
        state_nxt = S_DONE;
      end
      S_FOLD_CHK: begin
        if (stat.idx_ge2) begin
          op        = DP_FOLD_RD;
          state_nxt = S_FOLD_P;
        end else begin
          op        = DP_MAX_INIT;
          state_nxt = S_MAX_CHK;
        end
      end
      S_FOLD_P: begin
        op        = DP_FOLD_P;
        state_nxt = S_FOLD_WR;
      end
      S_FOLD_WR: begin
        op        = DP_FOLD_WR;
        state_nxt = S_FOLD_CHK;
      end
      S_MAX_CHK: begin
        if (stat.idx_lt_nt) begin
          op        = DP_MAX_RD;
          state_nxt = S_MAX_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MAX_MUL: begin
        op        = DP_MAX_MUL;
        state_nxt = S_MAX_CMP;
      end
      S_MAX_CMP: begin
        op        = DP_MAX_CMP;
        state_nxt = S_MAX_CHK;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          op        = DP_PUBLISH;
          reply_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (op == DP_PUBLISH) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      phase2_r    <= 1'b0;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase2_r    <= phase2_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Palindromic tree builder testbench
// Drives clear, append, finish and unused commands through the input channel
// with random gaps, stalls the result channel at random, and checks every
// result against a palindromic tree kept in a scoreboard object.
// ----------------------------------------------------------------------------
module tb;
  import ptb_pkg::*;

  localparam int TREE_LEN  = MAX_LEN_DEF;
  localparam int ABC       = ALPHABET_DEF;
  localparam int NODE_CAP  = TREE_LEN + 2;
  localparam int ITEM_GOAL = 1700;
  localparam opcode_t OP_UNUSED = opcode_t'(2'd3);

  class tree_scoreboard;
    logic [4:0] letters [0:TREE_LEN];
    int text_len, node_total, last_node;
    int node_len [0:NODE_CAP-1];
    int child [0:NODE_CAP*ABC-1];
    int link [0:NODE_CAP-1];
    int occ [0:NODE_CAP-1];
    int pal_total [0:NODE_CAP-1];
    bit finished;
    out_item_t expected_q [$];
    int mismatches, n_full, n_after, n_finish, n_clear, n_append;

    function void clear_tree();
      for (int i = 0; i <= TREE_LEN; i++) letters[i] = 5'd0;
      for (int i = 0; i < NODE_CAP; i++) begin
        node_len[i] = 0; link[i] = 0; occ[i] = 0; pal_total[i] = 0;
      end
      for (int i = 0; i < NODE_CAP*ABC; i++) child[i] = 0;
      letters[0] = 5'd31;
      text_len = 0; node_total = 2; last_node = 0;
      node_len[1] = -1; link[0] = 1; finished = 0;
    endfunction

    function int walk_links(int node);
      int pos;
      for (int s = 0; s < NODE_CAP + 1; s++) begin
        if (node >= node_total) return 1;
        pos = text_len - node_len[node] - 1;
        if (pos >= 0 && pos <= text_len && letters[pos] == letters[text_len]) return node;
        node = link[node];
      end
      return 1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int c, cur, nxt, fresh, lk, best, p, prod;
      logic [6:0] d;
      r = '0;
      if (it.opcode == OP_CLEAR) begin
        clear_tree();
        n_clear++;
      end else if (it.opcode == OP_APPEND) begin
        n_append++;
        if (finished) begin
          r.status = ST_AFTER_FINISH; n_after++;
        end else if (text_len >= TREE_LEN) begin
          r.status = ST_FULL; n_full++;
        end else begin
          d = it.char_code - LETTER_BASE;
          c = int'(d) % ABC;
          text_len++;
          letters[text_len] = c[4:0];
          cur = walk_links(last_node);
          nxt = child[cur*ABC + c];
          if (nxt == 0 && node_total < NODE_CAP) begin
            fresh = node_total;
            lk = 0;
            node_len[fresh] = node_len[cur] + 2;
            if (cur != 1) lk = child[walk_links(link[cur])*ABC + c];
            link[fresh] = lk;
            pal_total[fresh] = (pal_total[lk] + 1) & 2047;
            occ[fresh] = 0;
            child[cur*ABC + c] = fresh;
            node_total++;
            nxt = fresh;
            r.is_new = 1'b1;
          end
          last_node = nxt;
          occ[nxt] = (occ[nxt] + 1) & 2047;
          r.suffix_palindromes = COUNT_W'(pal_total[nxt]);
          r.longest_suffix_len = COUNT_W'(node_len[nxt]);
        end
      end else if (it.opcode == OP_FINISH) begin
        n_finish++;
        best = 0;
        if (!finished) begin
          for (int i = node_total; i > 2; i--) begin
            p = link[i-1];
            if (p >= 2 && p < node_total) occ[p] = (occ[p] + occ[i-1]) & 2047;
          end
          finished = 1;
        end
        for (int i = 2; i < node_total; i++) begin
          prod = occ[i] * node_len[i];
          if (prod > best) best = prod;
        end
        r.best_product = BEST_W'(best);
      end
      r.distinct_count = COUNT_W'(node_total - 2);
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status || got.suffix_palindromes !== e.suffix_palindromes ||
          got.longest_suffix_len !== e.longest_suffix_len || got.is_new !== e.is_new ||
          got.distinct_count !== e.distinct_count || got.best_product !== e.best_product)
      begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, actual %p", e, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  bit no_idle = 0;
  int sent = 0;
  tree_scoreboard sb;

  palindromic_tree_builder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  task automatic send_item(opcode_t op, logic [6:0] ch);
    in_item_t it;
    int gap;
    it.opcode = op;
    it.char_code = ch;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(it);
    sent++;
  endtask

  task automatic send_append(int span);
    logic [6:0] ch;
    if ($urandom_range(0, 40) == 0) ch = 7'($urandom_range(0, 127));
    else ch = LETTER_BASE + 7'($urandom_range(0, span - 1));
    send_item(OP_APPEND, ch);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int w;
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
    end
  end

  initial begin
    int len, span;
    sb = new();
    sb.clear_tree();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OP_APPEND, LETTER_BASE);
    send_item(OP_APPEND, LETTER_BASE + 7'd1);
    send_item(OP_APPEND, LETTER_BASE);
    send_item(OP_APPEND, LETTER_BASE);
    send_item(OP_APPEND, LETTER_BASE + 7'd25);
    send_item(OP_APPEND, 7'd0);
    send_item(OP_APPEND, 7'd127);
    send_item(OP_UNUSED, 7'h55);
    send_item(OP_APPEND, 7'h2a);
    send_item(OP_FINISH, 7'h7f);
    send_item(OP_APPEND, LETTER_BASE);
    send_item(OP_FINISH, 7'd0);
    send_item(OP_CLEAR, 7'h7f);
    send_item(OP_FINISH, 7'd0);
    send_item(OP_APPEND, LETTER_BASE);
    send_item(OP_CLEAR, 7'd0);
    wait_drained();

    // Fill the store completely, then push against the full limit.
    no_idle = 1;
    for (int i = 0; i < TREE_LEN + 4; i++) send_append(2);
    no_idle = 0;
    send_item(OP_FINISH, 7'd0);
    send_item(OP_CLEAR, 7'd0);

    while (sent < ITEM_GOAL) begin
      no_idle = ($urandom_range(0, 4) == 0);
      span = $urandom_range(1, 4) == 1 ? 26 : $urandom_range(1, 3);
      len = $urandom_range(10, 150);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 60) == 0) send_item(OP_UNUSED, 7'($urandom_range(0, 127)));
        else send_append(span);
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
      send_item(OP_FINISH, 7'($urandom_range(0, 127)));
      if ($urandom_range(0, 1)) send_append(span);
      if ($urandom_range(0, 2) == 0) send_item(OP_FINISH, 7'($urandom_range(0, 127)));
      send_item(OP_CLEAR, 7'($urandom_range(0, 127)));
    end
    no_idle = 0;
    wait_drained();
    repeat (100) @(posedge clk);

    $display("covered %0d commands: %0d appends, %0d finishes, %0d clears",
             sent, sb.n_append, sb.n_finish, sb.n_clear);
    $display("appends refused: %0d on a full store, %0d after finish", sb.n_full, sb.n_after);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("status: fail");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/ptb_pkg.sv
hdl/ptb_dp.sv
hdl/ptb_ctrl.sv
hdl/palindromic_tree_builder.sv
tb/sv/tb.sv
